@@ rtl/dstl_pkg.sv @@
// Shared types and codes for the dual symbol table block.
// No dependencies; the top level and dstl_cell refer to it by scoped names.
`default_nettype none

package dstl_pkg;

    // Operation codes carried in the request kind field
    typedef enum logic [1:0] {
        KIND_INSTALL = 2'd0,
        KIND_CHECK   = 2'd1,
        KIND_LOOKUP  = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // Status codes returned with every response
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNDECL = 2'd3
    } status_t;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    localparam int KeyWidth = 64;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic                tsel;
        logic                ins;
        logic                hit;
        logic [KeyWidth-1:0] key;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/dstl_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; used by the top level.
`default_nettype none

interface dstl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        table_sel;
    logic [63:0] name_key;

    modport source (output valid, output kind, output table_sel, output name_key,
                    input ready);
    modport sink   (input valid, input kind, input table_sel, input name_key,
                    output ready);
endinterface

interface dstl_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [1:0]  status;
    logic [6:0]  fill_count;
    logic [15:0] error_total;

    modport source (output valid, output found, output status, output fill_count,
                    output error_total, input ready);
    modport sink   (input valid, input found, input status, input fill_count,
                    input error_total, output ready);
endinterface

`default_nettype wire

@@ rtl/dual_symbol_table_insert_lookup_top.sv @@
// Top level of the dual symbol table: sequencer, fill levels, error counter,
// response register and the chain of dstl_cell entries. Uses dstl_pkg, dstl_if.
//
//  channel | dir | payload                                  | handshake
//  req     | in  | kind, table_sel, name_key                | valid/ready
//  rsp     | out | found, status, fill_count, error_total   | valid/ready
//
// After acceptance the search token is registered, then walks the chain one
// cell per cycle; as it leaves the chain the hit is latched and the sequencer
// enters the finish step, which loads the response register.
// One request is in flight at a time; the next is accepted while a response
// still waits to be taken. A stalled response holds the finish step until
// the response register frees. Reset clears fill levels and the error
// counter at once; stored keys need no clearing.
`default_nettype none

module dual_symbol_table_insert_lookup_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dstl_req_if.sink   req,
    dstl_rsp_if.source rsp
);

    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [FW-1:0] DepthVal = FW'(TABLE_DEPTH);
    localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - 8 * KEY_CHARS);

    dstl_pkg::state_t  state_reg, state_next;
    dstl_pkg::kind_t   kind_reg;
    logic              tsel_reg;
    logic              hit_reg;
    logic [FW-1:0]     fill_level_reg [2];
    logic [FW-1:0]     fill_new;
    logic [FW-1:0]     fill_sel;
    logic [FW+6:0]     fill_ext;
    logic [15:0]       error_counter_reg;
    logic [15:0]       err_new;
    logic              found_c;
    dstl_pkg::status_t status_c;
    logic              count_err;
    logic              req_take;
    logic              out_free;
    logic              finish;
    logic              rsp_valid_reg;
    logic              found_reg;
    logic [1:0]        status_reg;
    logic [6:0]        fill_out_reg;
    logic [15:0]       err_out_reg;
    dstl_pkg::token_t  tok_reg, tok_next;
    dstl_pkg::token_t  chain [TABLE_DEPTH+1];

    assign req_take = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign fill_sel = fill_level_reg[tsel_reg];

    // Sequencer: next state and ready
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            dstl_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = dstl_pkg::S_SEARCH;
                end
            end
            dstl_pkg::S_SEARCH:
            begin
                if (chain[TABLE_DEPTH].valid)
                begin
                    state_next = dstl_pkg::S_FINISH;
                end
            end
            dstl_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = dstl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dstl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dstl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Build the search token from an accepted request
    always_comb
    begin
        tok_next.valid = req_take;
        tok_next.tsel  = req.table_sel;
        tok_next.ins   = (dstl_pkg::kind_t'(req.kind) == dstl_pkg::KIND_INSTALL);
        tok_next.hit   = 1'b0;
        tok_next.key   = req.name_key & KeyMask;
    end

    // Launch the token; only the valid bit is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            kind_reg <= dstl_pkg::kind_t'(req.kind);
            tsel_reg <= req.table_sel;
        end
        if (chain[TABLE_DEPTH].valid)
        begin
            hit_reg <= chain[TABLE_DEPTH].hit;
        end
    end

    // Chain of entry cells
    assign chain[0] = tok_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        dstl_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .fill    (fill_sel),
            .tok_out (chain[i+1])
        );
    end

    // Decide status, fill level and error count at the finish step
    always_comb
    begin
        found_c   = hit_reg && (kind_reg != dstl_pkg::KIND_CLEAR);
        status_c  = dstl_pkg::ST_OK;
        count_err = 1'b0;
        fill_new  = fill_sel;
        case (kind_reg)
            dstl_pkg::KIND_INSTALL:
            begin
                if (found_c)
                begin
                    status_c  = dstl_pkg::ST_DUP;
                    count_err = 1'b1;
                end
                else if (fill_sel >= DepthVal)
                begin
                    status_c = dstl_pkg::ST_FULL;
                end
                else
                begin
                    fill_new = fill_sel + 1'b1;
                end
            end
            dstl_pkg::KIND_CHECK:
            begin
                if (!found_c)
                begin
                    status_c  = dstl_pkg::ST_UNDECL;
                    count_err = 1'b1;
                end
            end
            dstl_pkg::KIND_CLEAR:
            begin
                fill_new = '0;
            end
            default:
            begin
                status_c = dstl_pkg::ST_OK;
            end
        endcase
        err_new  = (count_err && (error_counter_reg != 16'hFFFF))
                 ? error_counter_reg + 16'd1 : error_counter_reg;
        fill_ext = {7'd0, fill_new};
    end

    // Update table state and the response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level_reg[0] <= '0;
            fill_level_reg[1] <= '0;
            error_counter_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                fill_level_reg[tsel_reg] <= fill_new;
                error_counter_reg        <= err_new;
                rsp_valid_reg            <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Load the response payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            found_reg    <= found_c;
            status_reg   <= status_c;
            fill_out_reg <= fill_ext[6:0];
            err_out_reg  <= err_new;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.status      = status_reg;
    assign rsp.fill_count  = fill_out_reg;
    assign rsp.error_total = err_out_reg;

    // Token leaves the chain only while a search is pending
    a_end_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain[TABLE_DEPTH].valid |-> state_reg == dstl_pkg::S_SEARCH)
        else $error("search token left the chain outside a search");

    // An accepted request starts a search
    a_take_search: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == dstl_pkg::S_SEARCH)
        else $error("accepted request did not start a search");

    // Fill levels never pass the table depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_level_reg[0] <= DepthVal && fill_level_reg[1] <= DepthVal)
        else $error("fill level beyond table depth");

    // Error counter never decreases
    a_err_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 error_counter_reg >= $past(error_counter_reg))
        else $error("error counter went down");

endmodule

`default_nettype wire

@@ rtl/dstl_cell.sv @@
// One table entry pair (one key per table) in the search chain.
// Depends on dstl_pkg for the token type.
`default_nettype none

module dstl_cell #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX         = 0
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dstl_pkg::token_t                      tok_in,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]      fill,
    output dstl_pkg::token_t                           tok_out
);

    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam logic [FW-1:0] IdxVal = FW'(IDX);

    logic [dstl_pkg::KeyWidth-1:0] key0_reg;
    logic [dstl_pkg::KeyWidth-1:0] key1_reg;
    logic [dstl_pkg::KeyWidth-1:0] stored;
    logic                          match;
    logic                          wr_en;
    dstl_pkg::token_t              tok_next;
    dstl_pkg::token_t              tok_reg;

    // Compare the passing key with this entry when the entry is filled
    always_comb
    begin
        stored   = tok_in.tsel ? key1_reg : key0_reg;
        match    = tok_in.valid && (IdxVal < fill) && (stored == tok_in.key);
        // Append at the first free entry when no earlier entry matched
        wr_en    = tok_in.valid && tok_in.ins && !tok_in.hit && (IdxVal == fill);
        tok_next = tok_in;
        tok_next.hit = tok_in.hit | match;
    end

    // Store the key of an install
    always_ff @(posedge clk)
    begin
        if (wr_en && !tok_in.tsel)
        begin
            key0_reg <= tok_in.key;
        end
        if (wr_en && tok_in.tsel)
        begin
            key1_reg <= tok_in.key;
        end
    end

    // Advance the token to the next cell; only the valid bit is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
